### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// implication checked at every rising edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

`endif

### hw/rtl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Types and constants shared by the priority point rasterizer modules.
// ----------------------------------------------------------------------------
package ppr_pkg;

	localparam int ADDR_W = 24;
	localparam logic [7:0] DEFAULT_PRIO_CLASS = 8'd6;
	localparam logic [7:0] COLOR_FULL = 8'd255;
	localparam logic [7:0] COLOR_DIM = 8'd85;

	typedef enum logic [1:0] {
		REQ_PRIO  = 2'd0,
		REQ_POINT = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_code_t;

	typedef enum logic [2:0] {
		CFG_ORIGIN_X  = 3'd0,
		CFG_ORIGIN_Y  = 3'd1,
		CFG_INV_GRID  = 3'd2,
		CFG_NUM_ROWS  = 3'd3,
		CFG_NUM_COLS  = 3'd4,
		CFG_BUILDING  = 3'd5
	} cfg_code_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_IDX,
		F_SEND
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RD,
		B_PRIO,
		B_DEC
	} back_state_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] point_z;
		logic [7:0]         point_class;
		logic [7:0]         priority_class;
		logic [15:0]        priority_value;
		logic [15:0]        cell_index;
	} req_t;

	typedef struct packed {
		logic [7:0]         cell_class;
		logic signed [31:0] cell_z;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               out_of_range;
	} res_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [23:0]        inv_grid_q16;
		logic [12:0]        num_rows;
		logic [12:0]        num_cols;
		logic [7:0]         building_class;
	} cfg_t;

	typedef struct packed {
		req_code_t          op;
		logic               valid;
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         point_class;
		logic signed [31:0] point_z;
		logic [7:0]         priority_class;
		logic [15:0]        priority_value;
	} cmd_t;

endpackage

### hw/rtl/ppr_ram.sv
// ----------------------------------------------------------------------------
// ppr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/ppr_fifo.sv
// ----------------------------------------------------------------------------
// ppr_fifo
// Two-entry queue that decouples producer and consumer.
// ----------------------------------------------------------------------------
module ppr_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

### hw/rtl/ppr_front.sv
// ----------------------------------------------------------------------------
// ppr_front
// Accepts requests, maps points to cells and checks read addresses.
// ----------------------------------------------------------------------------
module ppr_front import ppr_pkg::*; #(
	parameter int PIXEL_CAPACITY = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic clearing,
	input  logic push,
	input  req_t item,
	output logic full,
	output cmd_t cmd,
	output logic cmd_push,
	input  logic cmd_full
);

	localparam logic [25:0] CAP26 = 26'(PIXEL_CAPACITY);

	front_state_t       state_q, state_d;
	req_t               item_s1;
	logic [31:0]        dx_s1, dy_s1;
	logic               negx_s1, negy_s1;
	logic [55:0]        prodx_s2, prody_s2;
	logic               okc_s3;
	logic [25:0]        idx_s3, cells_s3;
	logic signed [32:0] dx_w, dy_w;
	logic [39:0]        qx, qy;
	logic [12:0]        rowflip;
	logic               accept;

	assign accept = push && !full;
	assign full   = (state_q != F_IDLE) || clearing;
	assign dx_w   = $signed({item.coord_x[31], item.coord_x}) -
	                $signed({cfg.origin_x[31], cfg.origin_x});
	assign dy_w   = $signed({item.coord_y[31], item.coord_y}) -
	                $signed({cfg.origin_y[31], cfg.origin_y});
	assign qx      = prodx_s2[55:16];
	assign qy      = prody_s2[55:16];
	assign rowflip = cfg.num_rows - 13'd1 - qy[12:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			dx_s1   <= dx_w[31:0];
			dy_s1   <= dy_w[31:0];
			negx_s1 <= dx_w[32];
			negy_s1 <= dy_w[32];
		end
		if (state_q == F_MUL) begin
			prodx_s2 <= 56'(dx_s1) * 56'(cfg.inv_grid_q16);
			prody_s2 <= 56'(dy_s1) * 56'(cfg.inv_grid_q16);
		end
		if (state_q == F_IDX) begin
			okc_s3   <= !negx_s1 && !negy_s1 && (qx < 40'(cfg.num_cols)) &&
			            (qy < 40'(cfg.num_rows));
			idx_s3   <= 26'(rowflip) * 26'(cfg.num_cols) + 26'(qx[12:0]);
			cells_s3 <= 26'(cfg.num_rows) * 26'(cfg.num_cols);
		end
	end

	always_comb begin
		cmd.op             = req_code_t'(item_s1.req_type);
		cmd.point_class    = item_s1.point_class;
		cmd.point_z        = item_s1.point_z;
		cmd.priority_class = item_s1.priority_class;
		cmd.priority_value = item_s1.priority_value;
		if (cmd.op == REQ_READ) begin
			cmd.valid = (26'(item_s1.cell_index) < cells_s3) &&
			            (26'(item_s1.cell_index) < CAP26);
			cmd.addr  = ADDR_W'(item_s1.cell_index);
		end else begin
			cmd.valid = okc_s3 && (idx_s3 < CAP26);
			cmd.addr  = idx_s3[ADDR_W-1:0];
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_push = 1'b0;
		unique case (state_q)
			F_IDLE: if (accept) state_d = F_MUL;
			F_MUL:  state_d = F_IDX;
			F_IDX:  state_d = F_SEND;
			F_SEND: begin
				if (!cmd_full) begin
					cmd_push = 1'b1;
					state_d  = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

endmodule

### hw/rtl/ppr_back.sv
// ----------------------------------------------------------------------------
// ppr_back
// Executes commands against the cell stores and the priority table.
// ----------------------------------------------------------------------------
module ppr_back import ppr_pkg::*; #(
	parameter int PIXEL_CAPACITY = 65536,
	parameter int CLASS_COUNT    = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	output logic clearing,
	input  cmd_t head,
	input  logic cmd_empty,
	output logic cmd_pop,
	output res_t res,
	output logic res_push,
	input  logic res_full
);

	localparam int PIX_AW = $clog2(PIXEL_CAPACITY);
	localparam int CLS_AW = $clog2(CLASS_COUNT);
	localparam logic [PIX_AW-1:0] CLR_LAST = PIX_AW'(PIXEL_CAPACITY - 1);
	localparam logic [8:0] CLS_LIM = 9'(CLASS_COUNT);

	back_state_t        state_q, state_d;
	logic               clr_busy_q;
	logic [PIX_AW-1:0]  clr_cnt_q;
	logic [CLASS_COUNT-1:0] pv_valid_q;

	logic               cls_we;
	logic [PIX_AW-1:0]  cls_waddr;
	logic [7:0]         cls_wdata, cls_rd;
	logic               hgt_we;
	logic [31:0]        hgt_rd;
	logic               prio_we;
	logic [15:0]        prio_a, prio_b, pn, po;
	logic               take, do_store, do_prio;

	assign clearing = clr_busy_q;

	function automatic logic [15:0] prio_eff(input logic [7:0] cls, input logic [15:0] rd,
			input logic [CLASS_COUNT-1:0] vld);
		logic [15:0] p;
		if (9'(cls) >= CLS_LIM) p = 16'd0;
		else if (vld[cls[CLS_AW-1:0]]) p = rd;
		else p = (cls == DEFAULT_PRIO_CLASS) ? 16'd1 : 16'd0;
		return p;
	endfunction

	ppr_ram #(.WIDTH(8), .DEPTH(PIXEL_CAPACITY)) u_cls (
		.clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
		.raddr(head.addr[PIX_AW-1:0]), .rdata(cls_rd)
	);

	ppr_ram #(.WIDTH(32), .DEPTH(PIXEL_CAPACITY)) u_hgt (
		.clk(clk), .we(hgt_we), .waddr(head.addr[PIX_AW-1:0]), .wdata(head.point_z),
		.raddr(head.addr[PIX_AW-1:0]), .rdata(hgt_rd)
	);

	ppr_ram #(.WIDTH(16), .DEPTH(CLASS_COUNT)) u_prio_new (
		.clk(clk), .we(prio_we), .waddr(head.priority_class[CLS_AW-1:0]),
		.wdata(head.priority_value), .raddr(head.point_class[CLS_AW-1:0]), .rdata(prio_a)
	);

	ppr_ram #(.WIDTH(16), .DEPTH(CLASS_COUNT)) u_prio_old (
		.clk(clk), .we(prio_we), .waddr(head.priority_class[CLS_AW-1:0]),
		.wdata(head.priority_value), .raddr(cls_rd[CLS_AW-1:0]), .rdata(prio_b)
	);

	assign pn   = prio_eff(head.point_class, prio_a, pv_valid_q);
	assign po   = prio_eff(cls_rd, prio_b, pv_valid_q);
	assign take = (cls_rd == 8'd0) || (pn > po) ||
	              ((pn == po) && ($signed(hgt_rd) < head.point_z));

	assign do_store = (head.op == REQ_POINT) && head.valid && take;
	assign do_prio  = (head.op == REQ_PRIO) && (head.priority_class != 8'd0) &&
	                  (9'(head.priority_class) < CLS_LIM);

	always_comb begin
		if (clr_busy_q) begin
			cls_we    = 1'b1;
			cls_waddr = clr_cnt_q;
			cls_wdata = 8'd0;
		end else begin
			cls_we    = res_push && do_store;
			cls_waddr = head.addr[PIX_AW-1:0];
			cls_wdata = head.point_class;
		end
	end
	assign hgt_we  = res_push && do_store;
	assign prio_we = res_push && do_prio;

	always_comb begin
		res = '0;
		unique case (head.op)
			REQ_POINT: res.out_of_range = !head.valid;
			REQ_READ: begin
				res.red          = COLOR_FULL;
				res.out_of_range = !head.valid;
				if (head.valid) begin
					res.cell_class = cls_rd;
					res.cell_z     = hgt_rd;
				end
				if (head.valid && (cls_rd == cfg.building_class)) begin
					res.green = COLOR_DIM;
					res.blue  = COLOR_DIM;
				end else begin
					res.green = COLOR_FULL;
					res.blue  = COLOR_FULL;
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			pv_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + PIX_AW'(1);
				if (clr_cnt_q == CLR_LAST) clr_busy_q <= 1'b0;
			end
			if (prio_we) pv_valid_q[head.priority_class[CLS_AW-1:0]] <= 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_push = 1'b0;
		cmd_pop  = 1'b0;
		unique case (state_q)
			B_IDLE: if (!cmd_empty && !clr_busy_q) state_d = B_RD;
			B_RD:   state_d = B_PRIO;
			B_PRIO: state_d = B_DEC;
			B_DEC: begin
				if (!res_full) begin
					res_push = 1'b1;
					cmd_pop  = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

endmodule

### hw/rtl/priority_point_rasterizer.sv
// ----------------------------------------------------------------------------
// priority_point_rasterizer
// Bins classified points into a raster with class priority and height tie-break.
// ----------------------------------------------------------------------------
// Every request yields one result. The front maps a request in the steps
// capture, 32x24 coordinate multiply, cell index multiply and hand-off; the
// back does its read-modify-write of the cell stores in the steps wait, read,
// priority lookup, decide and write. The front takes a new request only once
// it has handed off the last; a command queue lets front and back overlap.
// After reset the class store is cleared one cell a cycle over all
// PIXEL_CAPACITY cells while full stays high.
module priority_point_rasterizer import ppr_pkg::*; #(
	parameter int PIXEL_CAPACITY = 65536,
	parameter int CLASS_COUNT    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  req_t        item,
	output logic        empty,
	input  logic        pop,
	output res_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd_in, cmd_head;
	res_t res_in;
	logic clearing, cmd_push, cmd_full, cmd_pop, cmd_empty, res_push, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x       <= '0;
			cfg_q.origin_y       <= '0;
			cfg_q.inv_grid_q16   <= 24'd65;
			cfg_q.num_rows       <= 13'd256;
			cfg_q.num_cols       <= 13'd256;
			cfg_q.building_class <= 8'd6;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: cfg_q.origin_x       <= cfg_data;
				CFG_ORIGIN_Y: cfg_q.origin_y       <= cfg_data;
				CFG_INV_GRID: cfg_q.inv_grid_q16   <= cfg_data[23:0];
				CFG_NUM_ROWS: cfg_q.num_rows       <= cfg_data[12:0];
				CFG_NUM_COLS: cfg_q.num_cols       <= cfg_data[12:0];
				CFG_BUILDING: cfg_q.building_class <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ppr_front #(.PIXEL_CAPACITY(PIXEL_CAPACITY)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .clearing(clearing),
		.push(push), .item(item), .full(full),
		.cmd(cmd_in), .cmd_push(cmd_push), .cmd_full(cmd_full)
	);

	ppr_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
		.clk(clk), .arst_n(arst_n), .push(cmd_push), .din(cmd_in), .full(cmd_full),
		.pop(cmd_pop), .dout(cmd_head), .empty(cmd_empty)
	);

	ppr_back #(.PIXEL_CAPACITY(PIXEL_CAPACITY), .CLASS_COUNT(CLASS_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .clearing(clearing),
		.head(cmd_head), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
		.res(res_in), .res_push(res_push), .res_full(res_full)
	);

	ppr_fifo #(.WIDTH($bits(res_t))) u_res_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .din(res_in), .full(res_full),
		.pop(pop), .dout(result), .empty(empty)
	);

endmodule

### hw/rtl/ppr_checker.sv
// ----------------------------------------------------------------------------
// ppr_checker
// Port-level checks on result consistency and request acceptance, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppr_checker import ppr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input res_t        result
);

	`ASSERT_IMPL(a_red_code, clk, arst_n, !empty,
		(result.red == COLOR_FULL) || (result.red == 8'd0))
	`ASSERT_IMPL(a_oor_empty_cell, clk, arst_n, !empty && result.out_of_range,
		(result.cell_class == 8'd0) && (result.cell_z == 32'sd0))
	`ASSERT_IMPL(a_green_blue, clk, arst_n, !empty, result.green == result.blue)
	`ASSERT_IMPL(a_accept_busy, clk, arst_n, push && !full, ##1 full)
	`ASSERT_IMPL(a_result_hold, clk, arst_n, !empty && !pop,
		##1 (!empty && $stable(result)))

endmodule

bind priority_point_rasterizer ppr_checker u_chk (.*);
